### hw/rtl/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg
// Shared types, constants and the CORDIC arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package ictf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int RAW_W   = 16;
    localparam int ACC_W   = 17;   // offset-corrected accel
    localparam int ANG_W   = 26;
    localparam int GYRO_W  = 32;
    localparam int WGT_W   = 16;
    localparam int HEAD_W  = 10;
    localparam int YAW_W   = 9;
    localparam int CFG_W   = 26;
    localparam int IDX_W   = 4;
    localparam int RAD_W   = 34;   // ax^2 + az^2
    localparam int ROOT_W  = 17;
    localparam int CX_W    = 30;   // CORDIC x/y datapath

    // register indexes
    localparam logic [IDX_W-1:0] REG_ACCEL_X_OFFSET = 4'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL_Y_OFFSET = 4'd1;
    localparam logic [IDX_W-1:0] REG_PITCH_ZERO     = 4'd2;
    localparam logic [IDX_W-1:0] REG_ROLL_ZERO      = 4'd3;
    localparam logic [IDX_W-1:0] REG_YAW_ZERO       = 4'd4;
    localparam logic [IDX_W-1:0] REG_GYRO_SMOOTHING = 4'd5;
    localparam logic [IDX_W-1:0] REG_BLEND_WEIGHT   = 4'd6;
    localparam logic [IDX_W-1:0] REG_HEADING_WEIGHT = 4'd7;

    localparam logic [WGT_W-1:0] BLEND_WEIGHT_RST   = 16'd64225;
    localparam logic [WGT_W-1:0] HEADING_WEIGHT_RST = 16'd3932;

    localparam logic signed [ANG_W-1:0] ANG_MAX = 26'sd33554431;
    localparam logic signed [ANG_W-1:0] ANG_MIN = -26'sd33554432;

    // round(n/200) as (((n + DIV_BIAS) >> 3) * ceil(2^28/25)) >> 28, minus 2^17
    localparam logic [26:0] DIV_BIAS  = 27'd26214500;   // 200*2^17 + rounding 100
    localparam logic [23:0] DIV_RECIP = 24'd10737419;
    localparam int          DIV_SHIFT = 28;
    localparam logic signed [19:0] DIV_K = 20'sd131072;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_PREP,
        LANE_SQRT,
        LANE_CORDIC,
        LANE_MUL,
        LANE_SUM
    } lane_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_BUSY,
        TOP_OUT
    } top_state_t;

    typedef struct packed {
        logic [WGT_W-1:0] gyro_smoothing;
        logic [WGT_W-1:0] blend_weight;
    } lane_cfg_t;

    function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/ictf_lane.sv
// ----------------------------------------------------------------------------
// ictf_lane
// One tilt axis: gyro low-pass, isqrt, vectoring CORDIC and complementary blend.
// ----------------------------------------------------------------------------
module ictf_lane #(
    parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [ictf_pkg::ACC_W-1:0]     num_in,
    input  logic signed [ictf_pkg::ACC_W-1:0]     sa_in,
    input  logic signed [ictf_pkg::ACC_W-1:0]     sb_in,
    input  logic signed [ictf_pkg::RAW_W-1:0]     gyro_raw,
    input  ictf_pkg::lane_cfg_t                   cfg,
    output logic                                  done,
    output logic signed [ictf_pkg::ANG_W-1:0]     est
);
    import ictf_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    lane_state_t state_reg, state_next;

    logic signed [ACC_W-1:0]    num_reg;
    logic        [RAD_W-1:0]    sqa_reg, sqb_reg;
    logic signed [49:0]         gp_old_reg, gp_new_reg;
    logic signed [GYRO_W-1:0]   gyro_sm_reg;
    logic        [46:0]         dprod_reg;
    logic signed [19:0]         d_reg;
    logic        [RAD_W-1:0]    rem_reg, res_reg, bit_reg;
    logic signed [CX_W-1:0]     x_reg, y_reg;
    logic signed [ANG_W-1:0]    z_reg;
    logic                       zero_reg;
    logic        [CW-1:0]       i_reg;
    logic signed [44:0]         p1_reg, p2_reg;
    logic signed [ANG_W-1:0]    est_reg;
    logic                       done_reg;

    // combinational helpers
    logic signed [25:0]         raw500;
    logic signed [49:0]         gsum;
    logic signed [33:0]         gyro_rnd;
    logic        [26:0]         dm;
    logic                       ge;
    logic        [RAD_W-1:0]    res_nx;
    logic signed [CX_W-1:0]     xs, ys;
    logic signed [ANG_W:0]      est_plus_d;
    logic signed [44:0]         bsum;
    logic signed [28:0]         brnd;
    logic signed [ANG_W-1:0]    acc_ang;

    always_comb
    begin
        raw500   = (26'(gyro_raw) <<< 9) - (26'(gyro_raw) <<< 3) - (26'(gyro_raw) <<< 2);
        gsum     = gp_old_reg + gp_new_reg + 50'sd32768;
        gyro_rnd = 34'(gsum >>> 16);
        dm       = 27'(gyro_sm_reg) + DIV_BIAS;
        ge       = rem_reg >= (res_reg + bit_reg);
        res_nx   = ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        xs       = x_reg >>> i_reg;
        ys       = y_reg >>> i_reg;
        acc_ang  = zero_reg ? '0 : z_reg;
        est_plus_d = 27'(est_reg) + 27'(d_reg);
        bsum     = p1_reg + p2_reg + 45'sd32768;
        brnd     = 29'(bsum >>> 16);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LANE_IDLE:   if (start) state_next = LANE_PREP;
            LANE_PREP:   state_next = LANE_SQRT;
            LANE_SQRT:   if (bit_reg == RAD_W'(1)) state_next = LANE_CORDIC;
            LANE_CORDIC: if (i_reg == LAST_STEP) state_next = LANE_MUL;
            LANE_MUL:    state_next = LANE_SUM;
            LANE_SUM:    state_next = LANE_IDLE;
            default:     state_next = LANE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= LANE_IDLE;
            done_reg    <= 1'b0;
            gyro_sm_reg <= '0;
            est_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == LANE_SUM);
            if (state_reg == LANE_PREP)
                gyro_sm_reg <= GYRO_W'(gyro_rnd);
            if (state_reg == LANE_SUM)
            begin
                if (brnd > 29'(ANG_MAX))
                    est_reg <= ANG_MAX;
                else if (brnd < 29'(ANG_MIN))
                    est_reg <= ANG_MIN;
                else
                    est_reg <= ANG_W'(brnd);
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            LANE_IDLE:
            begin
                if (start)
                begin
                    num_reg    <= num_in;
                    sqa_reg    <= RAD_W'(sa_in * sa_in);
                    sqb_reg    <= RAD_W'(sb_in * sb_in);
                    gp_old_reg <= $signed({1'b0, cfg.gyro_smoothing}) * gyro_sm_reg;
                    gp_new_reg <= $signed(18'd65536 - 18'(cfg.gyro_smoothing)) * raw500;
                end
            end
            LANE_PREP:
            begin
                rem_reg <= sqa_reg + sqb_reg;
                res_reg <= '0;
                bit_reg <= RAD_W'(1) << 32;
            end
            LANE_SQRT:
            begin
                // gyro_sm is settled here; reciprocal divide by 200 in two steps
                dprod_reg <= 47'(dm >> 3) * 47'(DIV_RECIP);
                d_reg     <= $signed(20'(dprod_reg >> DIV_SHIFT)) - DIV_K;
                if (ge)
                    rem_reg <= rem_reg - (res_reg + bit_reg);
                res_reg <= res_nx;
                bit_reg <= bit_reg >> 2;
                x_reg    <= $signed({5'b0, res_nx[ROOT_W-1:0], 8'b0});
                y_reg    <= $signed({{5{num_reg[ACC_W-1]}}, num_reg, 8'b0});
                z_reg    <= '0;
                zero_reg <= (num_reg == '0) && (res_nx == '0);
                i_reg    <= '0;
            end
            LANE_CORDIC:
            begin
                if (!y_reg[CX_W-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_val(int'(i_reg));
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_val(int'(i_reg));
                end
                i_reg <= i_reg + CW'(1);
            end
            LANE_MUL:
            begin
                p1_reg <= 45'($signed({1'b0, cfg.blend_weight}) * est_plus_d);
                p2_reg <= 45'($signed(18'd65536 - 18'(cfg.blend_weight)) * acc_ang);
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign est  = est_reg;

endmodule

### hw/rtl/imu_complementary_tilt_filter_top.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top
// Pitch/roll complementary filter and heading smoother, two parallel tilt lanes.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one beat carries one IMU sample set.
//    in_stall is high from the accepted beat until the result is loaded into
//    the output register, so one sample is in flight at a time.
//  - Output channel (out_valid / out_stall): one result beat per input beat.
//    The output register frees the lanes: a new sample is taken while a
//    finished result is still waiting on a stalled receiver.
//  - From the accepting edge to out_valid: a prep state, 17 integer square
//    root steps, CORDIC_STEPS CORDIC steps, blend multiply and sum, lane
//    done and the output load. These iterations set the rate: the next
//    sample is taken only once the result is in the output register.
//  - Pitch and roll run in separate lanes side by side; the top merges them
//    with the heading path and adds the zero offsets.
//  - Configuration (cfg_we/cfg_index/cfg_data) is for the user to write only
//    while idle; the block does not enforce it. Unknown indexes are ignored.
//  - Reset clears all filter state and loads default weights; no clearing pass.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_top #(
    parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ictf_pkg::RAW_W-1:0]   accel_x_raw,
    input  logic signed [ictf_pkg::RAW_W-1:0]   accel_y_raw,
    input  logic signed [ictf_pkg::RAW_W-1:0]   accel_z_raw,
    input  logic signed [ictf_pkg::RAW_W-1:0]   gyro_x_raw,
    input  logic signed [ictf_pkg::RAW_W-1:0]   gyro_y_raw,
    input  logic signed [ictf_pkg::HEAD_W-1:0]  heading_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ictf_pkg::ANG_W-1:0]   pitch_rel,
    output logic signed [ictf_pkg::ANG_W-1:0]   roll_rel,
    output logic signed [ictf_pkg::ANG_W-1:0]   pitch_abs,
    output logic signed [ictf_pkg::ANG_W-1:0]   roll_abs,
    output logic        [ictf_pkg::YAW_W-1:0]   yaw_deg,
    input  logic                                cfg_we,
    input  logic        [ictf_pkg::IDX_W-1:0]   cfg_index,
    input  logic        [ictf_pkg::CFG_W-1:0]   cfg_data
);
    import ictf_pkg::*;

    // configuration registers
    logic signed [RAW_W-1:0]  ax_off_reg, ay_off_reg;
    logic signed [ANG_W-1:0]  pitch_zero_reg, roll_zero_reg;
    logic signed [HEAD_W-1:0] yaw_zero_reg;
    logic        [WGT_W-1:0]  gyro_sm_w_reg, blend_w_reg, head_w_reg;

    top_state_t state_reg, state_next;

    logic                     accept;
    logic                     start_reg;
    logic signed [27:0]       hp_reg;
    logic signed [HEAD_W-1:0] head_avg_reg;
    logic                     out_valid_reg;
    logic signed [ANG_W-1:0]  pitch_rel_reg, roll_rel_reg, pitch_abs_reg, roll_abs_reg;
    logic        [YAW_W-1:0]  yaw_reg;

    logic signed [ACC_W-1:0]  ax, ay, az, neg_ax;
    lane_cfg_t                lcfg;
    logic                     p_done, r_done;
    logic signed [ANG_W-1:0]  p_est, r_est;
    logic                     load_out;

    logic signed [27:0]       hp_abs;
    logic signed [HEAD_W-1:0] h_trunc;
    logic        [11:0]       yaw_work;
    logic signed [ANG_W:0]    pa_sum, ra_sum;
    logic signed [ANG_W-1:0]  pa_sat, ra_sat;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != TOP_IDLE);
    assign load_out = (state_reg == TOP_OUT) && (!out_valid_reg || !out_stall);

    assign ax     = ACC_W'(accel_x_raw) - ACC_W'(ax_off_reg);
    assign ay     = ACC_W'(accel_y_raw) - ACC_W'(ay_off_reg);
    assign az     = ACC_W'(accel_z_raw);
    assign neg_ax = -ax;

    assign lcfg.gyro_smoothing = gyro_sm_w_reg;
    assign lcfg.blend_weight   = blend_w_reg;

    // pitch lane: atan2(ay, sqrt(ax^2 + az^2)) with gyro X
    ictf_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .num_in   (ay),
        .sa_in    (ax),
        .sb_in    (az),
        .gyro_raw (gyro_x_raw),
        .cfg      (lcfg),
        .done     (p_done),
        .est      (p_est)
    );

    // roll lane: atan2(-ax, sqrt(ay^2 + az^2)) with gyro Y
    ictf_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .num_in   (neg_ax),
        .sa_in    (ay),
        .sb_in    (az),
        .gyro_raw (gyro_y_raw),
        .cfg      (lcfg),
        .done     (r_done),
        .est      (r_est)
    );

    // merge: zero offsets, heading truncation and wrap
    always_comb
    begin
        hp_abs  = hp_reg[27] ? -hp_reg : hp_reg;
        h_trunc = hp_reg[27] ? -HEAD_W'(hp_abs >>> 16) : HEAD_W'(hp_reg >>> 16);

        // h - yaw_zero lies in -1023..1023; bias by 3*360 and fold down
        yaw_work = 12'(12'(head_avg_reg) - 12'(yaw_zero_reg) + 12'd1080);
        for (int k = 0; k < 5; k++)
        begin
            if (yaw_work >= 12'd360)
                yaw_work = yaw_work - 12'd360;
        end

        pa_sum = 27'(p_est) + 27'(pitch_zero_reg);
        ra_sum = 27'(r_est) + 27'(roll_zero_reg);
        if (pa_sum > 27'(ANG_MAX))      pa_sat = ANG_MAX;
        else if (pa_sum < 27'(ANG_MIN)) pa_sat = ANG_MIN;
        else                            pa_sat = ANG_W'(pa_sum);
        if (ra_sum > 27'(ANG_MAX))      ra_sat = ANG_MAX;
        else if (ra_sum < 27'(ANG_MIN)) ra_sat = ANG_MIN;
        else                            ra_sat = ANG_W'(ra_sum);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE: if (accept) state_next = TOP_BUSY;
            TOP_BUSY: if (p_done) state_next = TOP_OUT;
            TOP_OUT:  if (load_out) state_next = TOP_IDLE;
            default:  state_next = TOP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= TOP_IDLE;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            head_avg_reg   <= '0;
            ax_off_reg     <= '0;
            ay_off_reg     <= '0;
            pitch_zero_reg <= '0;
            roll_zero_reg  <= '0;
            yaw_zero_reg   <= '0;
            gyro_sm_w_reg  <= '0;
            blend_w_reg    <= BLEND_WEIGHT_RST;
            head_w_reg     <= HEADING_WEIGHT_RST;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (start_reg)
                head_avg_reg <= h_trunc;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACCEL_X_OFFSET: ax_off_reg     <= cfg_data[RAW_W-1:0];
                    REG_ACCEL_Y_OFFSET: ay_off_reg     <= cfg_data[RAW_W-1:0];
                    REG_PITCH_ZERO:     pitch_zero_reg <= cfg_data[ANG_W-1:0];
                    REG_ROLL_ZERO:      roll_zero_reg  <= cfg_data[ANG_W-1:0];
                    REG_YAW_ZERO:       yaw_zero_reg   <= cfg_data[HEAD_W-1:0];
                    REG_GYRO_SMOOTHING: gyro_sm_w_reg  <= cfg_data[WGT_W-1:0];
                    REG_BLEND_WEIGHT:   blend_w_reg    <= cfg_data[WGT_W-1:0];
                    REG_HEADING_WEIGHT: head_w_reg     <= cfg_data[WGT_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            hp_reg <= 28'($signed({1'b0, head_w_reg}) * heading_in)
                    + 28'($signed(18'd65536 - 18'(head_w_reg)) * head_avg_reg);
        if (load_out)
        begin
            pitch_rel_reg <= p_est;
            roll_rel_reg  <= r_est;
            pitch_abs_reg <= pa_sat;
            roll_abs_reg  <= ra_sat;
            yaw_reg       <= YAW_W'(yaw_work);
        end
    end

    assign out_valid = out_valid_reg;
    assign pitch_rel = pitch_rel_reg;
    assign roll_rel  = roll_rel_reg;
    assign pitch_abs = pitch_abs_reg;
    assign roll_abs  = roll_abs_reg;
    assign yaw_deg   = yaw_reg;

`ifndef SYNTH
    // both lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        p_done == r_done)
        else $error("tilt lanes out of step");

    // lanes finish only while an item is in flight
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        p_done |-> (state_reg == TOP_BUSY))
        else $error("lane done outside busy state");

    // an accepted beat blocks the input until the result is loaded
    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after accept");

    // wrapped heading is always in range
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (yaw_deg < 9'd360))
        else $error("yaw out of range");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt filter: a directed table of sample sets
// and register settings, then random IMU traffic with random gaps and stalls
// on both channels. Each result beat is compared against a typed-in row or a
// bit-exact predictor of gyro filter, CORDIC tilt, blend, heading smoother.
// ----------------------------------------------------------------------------
module tb_top;
    import ictf_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 60;
    localparam int  N_RANDOM    = 480;

    // index with no register behind it
    localparam logic [IDX_W-1:0] REG_UNUSED = 4'd15;

    typedef struct {
        logic signed [RAW_W-1:0]  ax, ay, az, gx, gy;
        logic signed [HEAD_W-1:0] hd;
    } sample_t;

    typedef struct {
        logic signed [ANG_W-1:0] p_rel, r_rel, p_abs, r_abs;
        logic [YAW_W-1:0]        yaw;
    } attitude_t;

    // directed row: a sample set plus an optional typed-in expectation
    typedef struct {
        sample_t   s;
        bit        fixed;
        attitude_t a;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [RAW_W-1:0]  accel_x_raw = '0, accel_y_raw = '0, accel_z_raw = '0;
    logic signed [RAW_W-1:0]  gyro_x_raw = '0, gyro_y_raw = '0;
    logic signed [HEAD_W-1:0] heading_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [ANG_W-1:0] pitch_rel, roll_rel, pitch_abs, roll_abs;
    logic [YAW_W-1:0] yaw_deg;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    imu_complementary_tilt_filter_top u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of registers and filter state
    longint m_ax_off, m_ay_off, m_p_zero, m_r_zero, m_yaw_zero;
    longint m_gsmooth, m_blend, m_hweight;
    longint m_gx, m_gy, m_pitch, m_roll, m_head;

    attitude_t attitude_q[$];
    int        errors = 0;
    int        cycles = 0;
    int        rx_wait = 0;
    bit        rx_on = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;   // longint is signed, so arithmetic shift floors
    endfunction

    function automatic longint round_q16(longint v);
        return floor_shr(v + 32768, 16);
    endfunction

    function automatic longint clamp_ang(longint v);
        if (v > 64'sd33554431) return 64'sd33554431;
        if (v < -64'sd33554432) return -64'sd33554432;
        return v;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint tilt_atan2(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + atan_val(i);
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - atan_val(i);
            end
        end
        return z;
    endfunction

    function automatic longint div_floor(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic void config_model(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        case (idx)
            REG_ACCEL_X_OFFSET: m_ax_off = longint'($signed(v[15:0]));
            REG_ACCEL_Y_OFFSET: m_ay_off = longint'($signed(v[15:0]));
            REG_PITCH_ZERO:     m_p_zero = longint'($signed(v));
            REG_ROLL_ZERO:      m_r_zero = longint'($signed(v));
            REG_YAW_ZERO:       m_yaw_zero = longint'($signed(v[9:0]));
            REG_GYRO_SMOOTHING: m_gsmooth = longint'(v[15:0]);
            REG_BLEND_WEIGHT:   m_blend = longint'(v[15:0]);
            REG_HEADING_WEIGHT: m_hweight = longint'(v[15:0]);
            default: ;
        endcase
    endfunction

    function automatic attitude_t track_attitude(sample_t s);
        longint ax, ay, az, acc_p, acc_r, dp, dr, n, h, y;
        attitude_t a;
        ax = longint'(s.ax) - m_ax_off;
        ay = longint'(s.ay) - m_ay_off;
        az = longint'(s.az);
        m_gx = round_q16(m_gsmooth * m_gx + (65536 - m_gsmooth) * (longint'(s.gx) * 500));
        m_gy = round_q16(m_gsmooth * m_gy + (65536 - m_gsmooth) * (longint'(s.gy) * 500));
        acc_p = tilt_atan2(ay, int_sqrt(ax * ax + az * az));
        acc_r = tilt_atan2(-ax, int_sqrt(ay * ay + az * az));
        dp = div_floor(m_gx + 100, 200);
        dr = div_floor(m_gy + 100, 200);
        m_pitch = clamp_ang(round_q16(m_blend * (m_pitch + dp) + (65536 - m_blend) * acc_p));
        m_roll  = clamp_ang(round_q16(m_blend * (m_roll + dr) + (65536 - m_blend) * acc_r));
        n = m_hweight * longint'(s.hd) + (65536 - m_hweight) * m_head;
        h = (n >= 0) ? (n >> 16) : -((-n) >> 16);
        m_head = h;
        y = (h - m_yaw_zero) % 360;
        if (y < 0) y = y + 360;
        a.p_rel = m_pitch[ANG_W-1:0];
        a.r_rel = m_roll[ANG_W-1:0];
        a.p_abs = ANG_W'(clamp_ang(m_pitch + m_p_zero));
        a.r_abs = ANG_W'(clamp_ang(m_roll + m_r_zero));
        a.yaw   = y[YAW_W-1:0];
        return a;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        config_model(idx, v);
    endtask

    // drops valid, waits until every result is back, then lets the block go quiet
    task automatic drain;
        in_valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // valid stays up after the accepting edge; the next call drops it for a gap
    task automatic send_sample(sample_t s, bit fixed, attitude_t fa);
        attitude_t a;
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        a = track_attitude(s);
        attitude_q.push_back(fixed ? fa : a);
        in_valid    <= 1'b1;
        accel_x_raw <= s.ax;
        accel_y_raw <= s.ay;
        accel_z_raw <= s.az;
        gyro_x_raw  <= s.gx;
        gyro_y_raw  <= s.gy;
        heading_in  <= s.hd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic sample_t rand_sample(bit tame);
        sample_t s;
        if (tame)
        begin
            // near-level device under gravity with modest rotation
            s.ax = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            s.ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            s.az = 16'sd16384 - $signed(16'($urandom_range(0, 6000)));
            s.gx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            s.gy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            s.hd = $signed(10'($urandom_range(0, 359)));
        end
        else
        begin
            s.ax = RAW_W'($urandom); s.ay = RAW_W'($urandom); s.az = RAW_W'($urandom);
            s.gx = RAW_W'($urandom); s.gy = RAW_W'($urandom); s.hd = HEAD_W'($urandom);
        end
        return s;
    endfunction

    // result side: random stall per beat, compare against the oldest entry
    always @(posedge clk)
    begin
        attitude_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rx_on)
        begin
            if (out_valid && !out_stall)
            begin
                if (attitude_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e  = attitude_q.pop_front();
                    if (pitch_rel !== e.p_rel)
                    begin $error("pitch_rel exp %0d got %0d", e.p_rel, pitch_rel); errors++; end
                    if (roll_rel !== e.r_rel)
                    begin $error("roll_rel exp %0d got %0d", e.r_rel, roll_rel); errors++; end
                    if (pitch_abs !== e.p_abs)
                    begin $error("pitch_abs exp %0d got %0d", e.p_abs, pitch_abs); errors++; end
                    if (roll_abs !== e.r_abs)
                    begin $error("roll_abs exp %0d got %0d", e.r_abs, roll_abs); errors++; end
                    if (yaw_deg !== e.yaw)
                    begin $error("yaw_deg exp %0d got %0d", e.yaw, yaw_deg); errors++; end
                end
                // wait for the next beat, counted while it is on offer
                rx_wait = $urandom_range(0, 7);
            end
            else if (out_valid && rx_wait != 0)
                rx_wait = rx_wait - 1;
            out_stall <= (rx_wait != 0);
        end
    end

    function automatic row_t mk(int ax, int ay, int az, int gx, int gy, int hd);
        row_t r;
        r.s.ax = RAW_W'(ax); r.s.ay = RAW_W'(ay); r.s.az = RAW_W'(az);
        r.s.gx = RAW_W'(gx); r.s.gy = RAW_W'(gy); r.s.hd = HEAD_W'(hd);
        r.fixed = 1'b0;
        r.a = '{default: '0};
        return r;
    endfunction

    initial
    begin
        row_t rows[$];
        row_t r;
        attitude_t none;
        none = '{default: '0};

        m_ax_off = 0; m_ay_off = 0; m_p_zero = 0; m_r_zero = 0; m_yaw_zero = 0;
        m_gsmooth = 0; m_blend = BLEND_WEIGHT_RST; m_hweight = HEADING_WEIGHT_RST;
        m_gx = 0; m_gy = 0; m_pitch = 0; m_roll = 0; m_head = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        rx_on = 1'b1;

        // all-zero sample after reset: zero vector gives zero angles, yaw 0
        r = mk(0, 0, 0, 0, 0, 0);
        r.fixed = 1'b1;
        rows.push_back(r);
        rows.push_back(mk(0, 16384, 0, 0, 0, 90));          // vertical, +90 pitch
        rows.push_back(mk(0, -16384, 0, 0, 0, -180));       // vertical, -90 pitch
        rows.push_back(mk(32767, 0, 0, 0, 0, 359));         // roll -90
        rows.push_back(mk(-32768, 0, 0, 0, 0, 511));        // out-of-range heading
        rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -512));
        rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 359));
        rows.push_back(mk(0, 0, 16384, 32767, -32768, 45));
        rows.push_back(mk(100, -200, -16384, 1000, -1000, 180));
        foreach (rows[i]) send_sample(rows[i].s, rows[i].fixed, none);
        drain();

        // extreme weights (blend 0, others 65535), offsets at both ends
        write_reg(REG_BLEND_WEIGHT, 26'd0);
        write_reg(REG_HEADING_WEIGHT, 26'd65535);
        write_reg(REG_GYRO_SMOOTHING, 26'd65535);
        write_reg(REG_ACCEL_X_OFFSET, 26'h0008000);
        write_reg(REG_ACCEL_Y_OFFSET, 26'h0007FFF);
        write_reg(REG_PITCH_ZERO, 26'h1FFFFFF);
        write_reg(REG_ROLL_ZERO, 26'h2000000);
        write_reg(REG_YAW_ZERO, 26'd359);
        write_reg(REG_UNUSED, 26'h3FFFFFF);
        rows.delete();
        rows.push_back(mk(32767, -32768, 0, 32767, 32767, 0));
        rows.push_back(mk(-32768, 32767, 100, -32768, -32768, 359));
        rows.push_back(mk(0, 0, -32768, 0, 0, -180));
        foreach (rows[i]) send_sample(rows[i].s, 1'b0, none);
        drain();

        // near-full gyro trust with big rates
        write_reg(REG_BLEND_WEIGHT, 26'd65535);
        write_reg(REG_GYRO_SMOOTHING, 26'd0);
        write_reg(REG_YAW_ZERO, 26'h3FF & -26'd359);
        write_reg(REG_PITCH_ZERO, 26'd0);
        write_reg(REG_ROLL_ZERO, 26'd0);
        for (int i = 0; i < 12; i++)
        begin
            r = mk(0, 0, 16384, (i < 9) ? 32767 : -32768, -32768, 300);
            send_sample(r.s, 1'b0, none);
        end
        drain();

        // random phases, each with fresh register values
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_ACCEL_X_OFFSET, CFG_W'($urandom_range(0, 65535)));
            write_reg(REG_ACCEL_Y_OFFSET, CFG_W'($urandom_range(0, 65535)));
            write_reg(REG_PITCH_ZERO, CFG_W'($urandom));
            write_reg(REG_ROLL_ZERO, CFG_W'($urandom));
            write_reg(REG_YAW_ZERO,
                      CFG_W'(10'($signed($urandom_range(0, 718)) - 359)));
            write_reg(REG_GYRO_SMOOTHING, CFG_W'($urandom_range(0, 65535)));
            write_reg(REG_BLEND_WEIGHT, (ph == 0) ? CFG_W'(BLEND_WEIGHT_RST)
                                                  : CFG_W'($urandom_range(0, 65535)));
            write_reg(REG_HEADING_WEIGHT, CFG_W'($urandom_range(0, 65535)));
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                send_sample(rand_sample($urandom_range(0, 3) != 0), 1'b0, none);
                // hold off once mid-phase until the pipe is empty
                if (i == 20)
                begin
                    in_valid <= 1'b0;
                    while (attitude_q.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
